@@ hw/rtl/ccu_pkg.sv @@
// Shared types, opcodes and helpers for the cube calculus unit.
`timescale 1ns / 1ps

package ccu_pkg;

  localparam int unsigned MaxVars   = 32;
  localparam int unsigned WordW     = 32;
  localparam int unsigned VarCountW = 6;
  localparam int unsigned CountW    = 6;
  localparam int unsigned PosW      = 5;

  typedef enum logic [3:0] {
    OpCombine   = 4'd0,
    OpDistance  = 4'd1,
    OpIntersect = 4'd2,
    OpImplies   = 4'd3,
    OpEqual     = 4'd4,
    OpCofCube   = 4'd5,
    OpCofVar    = 4'd6,
    OpBlock     = 4'd7,
    OpCover     = 4'd8,
    OpLower     = 4'd9,
    OpMerge     = 4'd10,
    OpFirstOne  = 4'd11,
    OpInvert    = 4'd12,
    OpCount     = 4'd13
  } cube_op_e;

  typedef enum logic [1:0] {
    CntZero = 2'd0,
    CntOne  = 2'd1,
    CntDc   = 2'd2
  } count_kind_e;

  typedef struct packed {
    logic [3:0]       opcode;
    logic [WordW-1:0] a_value;
    logic [WordW-1:0] a_dontcare;
    logic             a_invalid;
    logic [WordW-1:0] b_value;
    logic [WordW-1:0] b_dontcare;
    logic             b_invalid;
    logic [WordW-1:0] mask;
    logic [PosW-1:0]  bit_pos;
    logic             bit_val;
    logic [1:0]       count_kind;
  } cube_req_t;

  typedef struct packed {
    logic [WordW-1:0]  value;
    logic [WordW-1:0]  dontcare;
    logic              invalid;
    logic              ok;
    logic [CountW-1:0] count;
  } cube_res_t;

  // Low min(var_count, MaxVars) bits set.
  function automatic logic [WordW-1:0] full_mask(input logic [VarCountW-1:0] vc);
    logic [WordW-1:0] m;
    m = '0;
    for (int i = 0; i < WordW; i++) begin
      m[i] = (i < int'(vc)) && (i < MaxVars);
    end
    return m;
  endfunction

endpackage

@@ hw/rtl/ccu_popcount.sv @@
// Population count of one 32-bit word as a short adder tree.
`timescale 1ns / 1ps

module ccu_popcount (
  input  logic [ccu_pkg::WordW-1:0]  word_i,
  output logic [ccu_pkg::CountW-1:0] count_o
);
  import ccu_pkg::*;

  localparam int unsigned Nibbles = WordW / 4;

  logic [2:0] nib_cnt [Nibbles];

  always_comb begin
    for (int n = 0; n < Nibbles; n++) begin
      nib_cnt[n] = 3'(word_i[4*n]) + 3'(word_i[4*n+1])
                 + 3'(word_i[4*n+2]) + 3'(word_i[4*n+3]);
    end
  end

  always_comb begin
    count_o = '0;
    for (int n = 0; n < Nibbles; n++) begin
      count_o = count_o + CountW'(nib_cnt[n]);
    end
  end

endmodule

@@ hw/rtl/ccu_ops.sv @@
// Cube operation datapath: one operation per word, purely combinational.
`timescale 1ns / 1ps

module ccu_ops (
  input  ccu_pkg::cube_req_t        req_i,
  input  logic [ccu_pkg::WordW-1:0] full_i,
  output ccu_pkg::cube_res_t        res_o
);
  import ccu_pkg::*;

  logic [WordW-1:0]  av, ad, bv, bd, msk, posbit;
  logic [WordW-1:0]  diff_care, l1, l2, cbv, cbd, t_merge, t_first, cnt_word, pc_in;
  logic [CountW-1:0] pc_out;
  logic [WordW-1:0]  rv, rd;
  logic              rinv, ok;

  assign av     = req_i.a_value & full_i;
  assign ad     = req_i.a_dontcare & full_i;
  assign bv     = req_i.b_value & full_i;
  assign bd     = req_i.b_dontcare & full_i;
  assign msk    = req_i.mask & full_i;
  assign posbit = WordW'(1) << req_i.bit_pos;

  assign diff_care = (av ^ bv) & ~ad & full_i;
  assign l1        = av & ~ad;
  assign l2        = bv & ~bd;

  // cofactor by variable: B is the single literal at bit_pos
  assign cbv = (req_i.opcode == OpCofVar) ? (req_i.bit_val ? (posbit & full_i) : '0) : bv;
  assign cbd = (req_i.opcode == OpCofVar) ? (full_i & ~posbit) : bd;

  assign t_merge = ad | bd | (av ^ bv) | posbit;
  assign t_first = av & ~msk & full_i;

  always_comb begin
    case (req_i.count_kind)
      CntOne:  cnt_word = av & ~ad;
      CntZero: cnt_word = ~av & ~ad;
      default: cnt_word = ad;
    endcase
  end

  // one counter serves distance and count
  assign pc_in = (req_i.opcode == OpDistance) ? ((av ^ bv) & ~(ad | bd) & full_i)
                                              : (cnt_word & ~msk & full_i);

  ccu_popcount u_popcount (
    .word_i  (pc_in),
    .count_o (pc_out)
  );

  always_comb begin
    rv   = '0;
    rd   = '0;
    rinv = 1'b0;
    ok   = 1'b0;
    unique case (req_i.opcode)
      OpCombine: begin
        if (ad == bd && diff_care != '0 && (diff_care & (diff_care - WordW'(1))) == '0) begin
          rv = av;
          rd = diff_care | ad;
          ok = 1'b1;
        end else begin
          rinv = 1'b1;
        end
      end
      OpDistance: ;
      OpIntersect: begin
        rinv = ((l1 ^ l2) & ~(ad | bd) & full_i) != '0;
        rv   = l1 | l2;
        rd   = ad & bd;
      end
      OpImplies: ok = (diff_care == '0);
      OpEqual:   ok = (ad == bd) && (diff_care == '0);
      OpCofCube, OpCofVar: begin
        if (((av ^ cbv) & ~(cbd | ad) & full_i) != '0) begin
          rinv = 1'b1;
        end else begin
          rv = av & cbd;
          rd = (~cbd | ad) & full_i;
        end
      end
      OpBlock: rv = ~(bd | ad) & (av ^ bv);
      OpCover: rv = ~bd & (ad | (av ^ bv));
      OpLower: begin
        rd = ad | ~msk;
        rv = av & msk;
      end
      OpMerge: begin
        if (req_i.a_invalid) begin
          rv = bv | posbit;
          rd = bd & ~posbit;
        end else if (req_i.b_invalid) begin
          rv = av & ~posbit;
          rd = ad & ~posbit;
        end else begin
          rv = av & ~t_merge;
          rd = t_merge;
        end
      end
      OpFirstOne: rv = t_first & (~t_first + WordW'(1));
      OpInvert: begin
        rv   = ~av & ~ad;
        rd   = ad;
        rinv = req_i.a_invalid;
      end
      OpCount: ;
      default: ;
    endcase
  end

  always_comb begin
    res_o.value    = rv & full_i;
    res_o.dontcare = rd & full_i;
    res_o.invalid  = rinv;
    res_o.ok       = ok;
    res_o.count    = (req_i.opcode == OpDistance || req_i.opcode == OpCount) ? pc_out : '0;
  end

endmodule

@@ hw/rtl/cube_calculus_unit_top.sv @@
// Top level of the cube calculus unit: input register, datapath, result register.
`timescale 1ns / 1ps
//
//  channel   handshake                  payload
//  -------   ------------------------   ---------------------------------------------
//  in        in_valid_i / in_stall_o    opcode, cube A, cube B, mask, bit_pos, ...
//  out       out_valid_o / out_stall_i  result_value/dontcare/invalid, flag_ok, count
//  cfg       cfg_we_i                   cfg_wdata_i (var_count)
//
//  One word per cycle sustained while out_stall_i is low. An accepted word enters the input
//  register, the operation logic fills the result register once it is free, and out_valid_o
//  rises as it is filled (two registers from input to output).
//  Reset empties both stages and sets var_count to 32 (all variables).
//  in_stall_o rises only when both stages hold words and out_stall_i is high.

module cube_calculus_unit_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ccu_pkg::VarCountW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [3:0]                     opcode_i,
  input  logic [ccu_pkg::WordW-1:0]      a_value_i,
  input  logic [ccu_pkg::WordW-1:0]      a_dontcare_i,
  input  logic                           a_invalid_i,
  input  logic [ccu_pkg::WordW-1:0]      b_value_i,
  input  logic [ccu_pkg::WordW-1:0]      b_dontcare_i,
  input  logic                           b_invalid_i,
  input  logic [ccu_pkg::WordW-1:0]      mask_i,
  input  logic [ccu_pkg::PosW-1:0]       bit_pos_i,
  input  logic                           bit_val_i,
  input  logic [1:0]                     count_kind_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ccu_pkg::WordW-1:0]      result_value_o,
  output logic [ccu_pkg::WordW-1:0]      result_dontcare_o,
  output logic                           result_invalid_o,
  output logic                           flag_ok_o,
  output logic [ccu_pkg::CountW-1:0]     bit_count_o
);
  import ccu_pkg::*;

  logic [WordW-1:0] full_q;
  cube_req_t        req_q, req_d;
  cube_res_t        res_q, res_d;
  logic             s1_valid_q, s1_valid_d;
  logic             out_valid_q, out_valid_d;
  logic             s1_ready, s2_ready;

  // full mask kept decoded; the user must change var_count only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= full_mask(VarCountW'(MaxVars));
    end else if (cfg_we_i) begin
      full_q <= full_mask(cfg_wdata_i);
    end
  end

  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;

  always_comb begin
    req_d.opcode     = opcode_i;
    req_d.a_value    = a_value_i;
    req_d.a_dontcare = a_dontcare_i;
    req_d.a_invalid  = a_invalid_i;
    req_d.b_value    = b_value_i;
    req_d.b_dontcare = b_dontcare_i;
    req_d.b_invalid  = b_invalid_i;
    req_d.mask       = mask_i;
    req_d.bit_pos    = bit_pos_i;
    req_d.bit_val    = bit_val_i;
    req_d.count_kind = count_kind_i;
  end

  assign s1_valid_d  = s1_ready ? in_valid_i : s1_valid_q;
  assign out_valid_d = s2_ready ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      req_q <= req_d;
    end
  end

  ccu_ops u_ops (
    .req_i  (req_q),
    .full_i (full_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_value_o    = res_q.value;
  assign result_dontcare_o = res_q.dontcare;
  assign result_invalid_o  = res_q.invalid;
  assign flag_ok_o         = res_q.ok;
  assign bit_count_o       = res_q.count;

  // back-pressure only when both stages are full and the sink stalls
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with a free stage");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_ready) |=> out_valid_o)
    else $error("word lost between input and result register");

  a_ok_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && flag_ok_o) |-> !result_invalid_o)
    else $error("flag_ok together with invalid result");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bit_count_o <= CountW'(WordW)))
    else $error("bit count above word width");

endmodule
